/* rtl/bfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Bitmap geometry
  localparam int FRAME_COUNT = 65536;
  localparam int WORD_BITS   = 32;
  localparam int WORD_COUNT  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = $clog2(WORD_COUNT);
  localparam int PTR_W       = WORD_AW + 1;
  localparam int BIT_W       = $clog2(WORD_BITS);

  // Field widths
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_W-1:0] START_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0] END_RESET   = CFG_W'(16384);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FREE_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_END   = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_OOM   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_INIT,
    ST_RESULT
  } state_t;

  // First free bit of a bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_t;

endpackage

/* rtl/bitmap_frame_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// First-fit page frame allocator over a used/free bitmap in block RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: release_address; tuser: cmd
// m_*       out  m_tvalid/m_tready  tdata: frame_address;   tuser: status
// cfg_*     in   cfg_wr_en          cfg_index selects register, cfg_data value
//
// After reset a clearing pass marks all 2048 bitmap words used,
// and s_tready stays low until it ends.
// Allocate scans one word per cycle through the RAM read port and stops
// at the first word with a free frame, or after the last word when memory
// is full. Init rewrites all words at one per cycle; free is a
// read-modify-write of one word. One command is in flight at a time; a
// finished result waits in the output register, and the next beat is taken
// meanwhile.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core
  import bfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] release_address
  input  logic [CMD_W-1:0]      s_tuser,   // [1:0] cmd
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [ADDR_W-1:0]     m_tdata,   // [31:0] frame_address
  output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  state_t            state;
  state_t            state_next;
  logic [PTR_W-1:0]  ptr;
  logic              rd_pend;
  logic [WORD_AW-1:0] rd_idx;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic [CFG_W-1:0]  region_start;
  logic [CFG_W-1:0]  region_end;

  // RAM port controls
  logic               wr_en;
  logic [WORD_AW-1:0] wr_addr;
  word_t              wr_data;
  logic               rd_en;
  logic [WORD_AW-1:0] rd_addr;
  word_t              rd_data;

  // Word unit results
  word_t init_word;
  find_t find;
  word_t set_word;
  word_t clear_word;

  logic               in_beat;
  logic               out_free;
  logic               last_ptr;
  logic               ptr_in_range;
  logic               addr_oor;
  logic [WORD_AW-1:0] free_word;
  logic [BIT_W-1:0]   free_bit;
  cmd_t               in_cmd;

  assign in_beat      = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign last_ptr     = (ptr == PTR_W'(WORD_COUNT - 1));
  assign ptr_in_range = (ptr < PTR_W'(WORD_COUNT));
  assign in_cmd       = cmd_t'(s_tuser);
  // Frame number beyond the bitmap
  assign addr_oor     = (s_tdata >> PAGE_SHIFT) >= ADDR_W'(FRAME_COUNT);
  assign free_word    = addr_q[PAGE_SHIFT + BIT_W +: WORD_AW];
  assign free_bit     = addr_q[PAGE_SHIFT +: BIT_W];

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfa_word_unit u_word (
    .word_idx     (ptr),
    .rd_word      (rd_data),
    .region_start (region_start),
    .region_end   (region_end),
    .bit_sel      (free_bit),
    .init_word    (init_word),
    .find         (find),
    .set_word     (set_word),
    .clear_word   (clear_word)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (last_ptr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (in_cmd)
            CMD_ALLOC: state_next = ST_SCAN;
            CMD_FREE:  state_next = addr_oor ? ST_RESULT : ST_FREE_RD;
            CMD_INIT:  state_next = ST_INIT;
            CMD_NOP:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_SCAN: begin
        // Stop on the first word with a free bit, or after the last word
        if (rd_pend && (find.found || rd_idx == WORD_AW'(WORD_COUNT - 1))) begin
          state_next = ST_RESULT;
        end
      end
      ST_FREE_RD: state_next = ST_FREE_WR;
      ST_FREE_WR: state_next = ST_RESULT;
      ST_INIT: begin
        if (last_ptr) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM controls and handshake
  always_comb begin
    s_tready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = ptr[WORD_AW-1:0];
    wr_data  = '1;
    rd_en    = 1'b0;
    rd_addr  = ptr[WORD_AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SCAN: begin
        rd_en   = ptr_in_range;
        wr_en   = rd_pend && find.found;
        wr_addr = rd_idx;
        wr_data = set_word;
      end
      ST_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_word;
      end
      ST_FREE_WR: begin
        wr_en   = 1'b1;
        wr_addr = free_word;
        wr_data = clear_word;
      end
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = init_word;
      end
      ST_RESULT: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN) && rd_en;
      // Advance the word pointer in sweeping states, restart it when idle
      if (state == ST_IDLE) begin
        ptr <= '0;
      end else if (state == ST_CLEAR || state == ST_INIT ||
                   (state == ST_SCAN && ptr_in_range)) begin
        ptr <= ptr + PTR_W'(1);
      end
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= START_RESET;
      region_end   <= END_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FREE_START: region_start <= cfg_data;
        REG_FREE_END:   region_end   <= cfg_data;
        default:        region_end   <= region_end;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx <= ptr[WORD_AW-1:0];
    if (in_beat) begin
      addr_q     <= s_tdata;
      res_addr   <= '0;
      res_status <= (in_cmd == CMD_FREE && addr_oor) ? STATUS_RANGE : STATUS_OK;
    end
    if (state == ST_SCAN && rd_pend) begin
      if (find.found) begin
        res_addr <= ADDR_W'({rd_idx, find.bit_idx}) << PAGE_SHIFT;
      end else if (rd_idx == WORD_AW'(WORD_COUNT - 1)) begin
        res_status <= STATUS_OOM;
      end
    end
    if (state == ST_RESULT && out_free) begin
      m_tdata <= res_addr;
      m_tuser <= res_status;
    end
  end

`ifndef SYNTH
  // Out of memory always reports address zero
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_OOM) |-> (m_tdata == '0))
    else $error("out of memory result with nonzero address");

  // An accepted command always leaves the idle state
  assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state != ST_IDLE))
    else $error("command accepted without starting work");

  // Scan write-back only targets the word whose read just returned
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && wr_en) |-> (rd_pend && wr_addr == rd_idx))
    else $error("scan write to a word not just read");

  // No command is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_tready && wr_en))
    else $error("clearing pass stalled or accepting commands");
`endif

endmodule

/* rtl/bfa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bfa_word_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_word_unit
// Per-word bitmap logic shared by the alloc, free and init commands: init
// mask, first free bit, set and clear of one bit.
// ----------------------------------------------------------------------------
module bfa_word_unit
  import bfa_pkg::*;
(
  input  logic [PTR_W-1:0] word_idx,
  input  word_t            rd_word,
  input  logic [CFG_W-1:0] region_start,
  input  logic [CFG_W-1:0] region_end,
  input  logic [BIT_W-1:0] bit_sel,
  output word_t            init_word,
  output find_t            find,
  output word_t            set_word,
  output word_t            clear_word
);

  logic [CFG_W-1:0] end_c;
  logic [31:0]      w32;
  logic [31:0]      sw;
  logic [31:0]      ew;
  word_t            ge_mask;
  word_t            lt_mask;

  // Clamp the init range to the bitmap
  assign end_c = (32'(region_end) > 32'(FRAME_COUNT)) ? CFG_W'(FRAME_COUNT) : region_end;
  assign w32   = 32'(word_idx);
  assign sw    = 32'(region_start >> BIT_W);
  assign ew    = 32'(end_c >> BIT_W);

  always_comb begin
    if (w32 > sw) begin
      ge_mask = '1;
    end else if (w32 == sw) begin
      ge_mask = word_t'('1) << region_start[BIT_W-1:0];
    end else begin
      ge_mask = '0;
    end
    if (w32 < ew) begin
      lt_mask = '1;
    end else if (w32 == ew) begin
      lt_mask = ~(word_t'('1) << end_c[BIT_W-1:0]);
    end else begin
      lt_mask = '0;
    end
  end

  // Frames inside the range read as free, all others as used
  assign init_word = ~(ge_mask & lt_mask);

  // Lowest clear bit wins
  always_comb begin
    find = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        find.found   = 1'b1;
        find.bit_idx = BIT_W'(i);
      end
    end
  end

  assign set_word   = rd_word | (word_t'(1) << find.bit_idx);
  assign clear_word = rd_word & ~(word_t'(1) << bit_sel);

endmodule
